/* src/batch_to_space_address_map_macros.svh */
// Assertion macros for the batch-to-space address map.
`ifndef BATCH_TO_SPACE_ADDRESS_MAP_MACROS_SVH
`define BATCH_TO_SPACE_ADDRESS_MAP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define B2S_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define B2S_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/b2s_pkg.sv */
// Shared types and constants for the batch-to-space address map.
package b2s_pkg;

  localparam int unsigned IDX_W      = 31;
  localparam int unsigned ELEM_W     = 64;
  localparam int unsigned BS_W       = 7;
  localparam int unsigned CROP_W     = 12;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned OUT_W      = 15;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLK_FACTOR  = 3'd0,
    REG_TRIM_TOP    = 3'd1,
    REG_TRIM_LEFT   = 3'd2,
    REG_IN_WIDTH    = 3'd3,
    REG_IN_HEIGHT   = 3'd4,
    REG_OUT_BATCHES = 3'd5,
    REG_OUT_HEIGHT  = 3'd6,
    REG_OUT_WIDTH   = 3'd7
  } reg_idx_e;

  // Settings the remap stages read; the user must keep them stable while items are in flight (not enforced here).
  typedef struct packed {
    logic [BS_W-1:0]   blk_factor;
    logic [CROP_W-1:0] trim_top;
    logic [CROP_W-1:0] trim_left;
    logic [OUT_W-1:0]  out_height;
    logic [OUT_W-1:0]  out_width;
  } cfg_t;

endpackage

/* src/b2s_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
module b2s_div #(
  parameter int unsigned DW = 31,
  parameter int unsigned VW = 13,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] num_i,
  input  logic [VW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [DW-1:0] quo_o,
  output logic [VW-1:0] rem_o,
  output logic [SW-1:0] side_o
);

  logic          v_q    [DW];
  logic [DW-1:0] num_q  [DW];
  logic [VW-1:0] rem_q  [DW];
  logic [SW-1:0] side_q [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] num_in;
    logic [VW-1:0] rem_in;
    logic [SW-1:0] side_in;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;
    logic [DW-1:0] num_d;
    logic [VW-1:0] rem_d;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign num_in  = num_i;
      assign rem_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign num_in  = num_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      trial = {rem_in, num_in[DW-1]};
      diff  = trial - {1'b0, den_i};
      ge    = (trial >= {1'b0, den_i});
      rem_d = ge ? diff[VW-1:0] : trial[VW-1:0];
      num_d = {num_in[DW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k]  <= num_d;
        rem_q[k]  <= rem_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[DW-1];
  assign quo_o   = num_q[DW-1];
  assign rem_o   = rem_q[DW-1];
  assign side_o  = side_q[DW-1];

endmodule

/* src/b2s_remap.sv */
// Scale, crop, bounds-check and re-linearize stages of the address map.
module b2s_remap #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned CHW   = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  b2s_pkg::cfg_t                cfg_i,
  input  logic                         valid_i,
  input  logic [CHW-1:0]               ch_i,
  input  logic [b2s_pkg::DIM_W-1:0]    col_i,
  input  logic [b2s_pkg::DIM_W-1:0]    row_i,
  input  logic [b2s_pkg::DIM_W-1:0]    ob_i,
  input  logic [b2s_pkg::IDX_W-1:0]    off_h_i,
  input  logic [b2s_pkg::BS_W-1:0]     off_w_i,
  input  logic [b2s_pkg::ELEM_W-1:0]   elem_i,
  output logic                         valid_o,
  output logic [b2s_pkg::IDX_W-1:0]    dst_o,
  output logic [b2s_pkg::ELEM_W-1:0]   elem_o,
  output logic                         ok_o
);

  localparam int unsigned NS   = 5;
  localparam int unsigned PW   = b2s_pkg::DIM_W + b2s_pkg::BS_W;
  localparam int unsigned SUMW = b2s_pkg::IDX_W + 2;
  localparam int unsigned SGW  = SUMW + 1;
  localparam int unsigned OW   = b2s_pkg::OUT_W;
  localparam int unsigned IW   = b2s_pkg::IDX_W;

  logic [NS-1:0] v_q;
  logic [b2s_pkg::ELEM_W-1:0] elem_q [NS];
  logic [CHW-1:0]             ch_q   [NS];

  // stage 1: scale by block size, add block offset
  logic [PW-1:0]             rb, cb;
  logic [SUMW-1:0]           hs_d, ws_d, hs_q, ws_q;
  logic [b2s_pkg::DIM_W-1:0] ob1_q;
  // stage 2: crop and bounds check
  logic signed [SGW-1:0]     oh_s, ow_s;
  logic                      ok_d, ok2_q, ok3_q, ok4_q, ok5_q;
  logic [OW-1:0]             oh_q, ow_q, ow3_q;
  logic [b2s_pkg::DIM_W-1:0] ob2_q;
  // stages 3..5: linearize
  logic [b2s_pkg::DIM_W+OW-1:0] p1;
  logic [IW+OW-1:0]             p2;
  logic [IW-1:0]                p3;
  logic [IW-1:0]                t1_d, t1_q, t2_d, t2_q, t3_d, t3_q;

  always_comb begin
    rb   = PW'(row_i) * PW'(cfg_i.blk_factor);
    cb   = PW'(col_i) * PW'(cfg_i.blk_factor);
    hs_d = SUMW'(rb) + SUMW'(off_h_i);
    ws_d = SUMW'(cb) + SUMW'(off_w_i);

    oh_s = $signed({1'b0, hs_q}) - $signed(SGW'(cfg_i.trim_top));
    ow_s = $signed({1'b0, ws_q}) - $signed(SGW'(cfg_i.trim_left));
    ok_d = !oh_s[SGW-1] && !ow_s[SGW-1] &&
           (oh_s[SUMW-1:0] < SUMW'(cfg_i.out_height)) &&
           (ow_s[SUMW-1:0] < SUMW'(cfg_i.out_width));

    p1   = (b2s_pkg::DIM_W+OW)'(ob2_q) * (b2s_pkg::DIM_W+OW)'(cfg_i.out_height);
    t1_d = IW'(p1) + IW'(oh_q);

    p2   = (IW+OW)'(t1_q) * (IW+OW)'(cfg_i.out_width);
    t2_d = p2[IW-1:0] + IW'(ow3_q);

    p3   = t2_q * IW'(DEPTH);
    t3_d = ok4_q ? (p3 + IW'(ch_q[3])) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      elem_q[0] <= elem_i;
      ch_q[0]   <= ch_i;
      for (int i = 1; i < NS; i++) begin
        elem_q[i] <= elem_q[i-1];
        ch_q[i]   <= ch_q[i-1];
      end
      hs_q  <= hs_d;
      ws_q  <= ws_d;
      ob1_q <= ob_i;
      ok2_q <= ok_d;
      oh_q  <= oh_s[OW-1:0];
      ow_q  <= ow_s[OW-1:0];
      ob2_q <= ob1_q;
      ok3_q <= ok2_q;
      ow3_q <= ow_q;
      t1_q  <= t1_d;
      ok4_q <= ok3_q;
      t2_q  <= t2_d;
      ok5_q <= ok4_q;
      t3_q  <= t3_d;
    end
  end

  assign valid_o = v_q[NS-1];
  assign dst_o   = t3_q;
  assign elem_o  = elem_q[NS-1];
  assign ok_o    = ok5_q;

endmodule

/* src/batch_to_space_address_map.sv */
// Top level of the batch-to-space address map: config registers, divider chain, remap.
//
//   channel  dir  fields (lowest bit first)
//   s_axis   in   tdata: src_index[30:0], elem_value[94:31], pad[95]
//   m_axis   out  tdata: dst_index[30:0], elem_out[94:31], pad[95]; tuser: write_ok
//   cfg      in   cfg_we_i, cfg_idx_i (register index), cfg_data_i
//
// One item enters per cycle unless the pipeline holds (see below).
// The channel is split off in three stages by a reciprocal multiply with the
// constant depth; then four dividers in a row (input width, input height,
// output batches, block size) each give one quotient bit per stage,
// followed by five stages of scale, crop, bounds check and multiply-add.
// All stages advance together; they hold while the output item waits, so
// s_axis_tready drops only when the output register is full and not taken.
// Reset clears valid bits and loads the register defaults.
`include "batch_to_space_address_map_macros.svh"

module batch_to_space_address_map #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [95:0]                        s_axis_tdata,  // src_index, elem_value
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [95:0]                        m_axis_tdata,  // dst_index, elem_out
  output logic                               m_axis_tuser,  // write_ok
  input  logic                               cfg_we_i,
  input  logic [b2s_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [b2s_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned IW  = b2s_pkg::IDX_W;
  localparam int unsigned EW  = b2s_pkg::ELEM_W;
  localparam int unsigned DMW = b2s_pkg::DIM_W;
  localparam int unsigned BW  = b2s_pkg::BS_W;
  localparam int unsigned CHW = $clog2(DEPTH + 1);
  localparam int unsigned S2W = EW + CHW;
  localparam int unsigned S3W = S2W + DMW;
  localparam int unsigned S4W = S3W + DMW;
  localparam int unsigned S5W = S4W + DMW;

  // Reciprocal for the channel split: floor(x / DEPTH) = (x * RECIP) >> SH
  // for every 31-bit x, with RECIP = ceil(2^SH / DEPTH) at most 33 bits.
  localparam int unsigned CL  = $clog2(DEPTH);
  localparam int unsigned SH  = IW + CL;
  localparam int unsigned RW  = IW + 2;
  localparam int unsigned LOW = 16;
  localparam int unsigned HIW = IW - LOW;
  localparam int unsigned PLW = LOW + RW;
  localparam int unsigned PHW = HIW + RW;
  localparam int unsigned SMW = PHW + LOW;
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << SH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

  // ---- configuration registers ----
  logic [BW-1:0]                 bs_q;
  logic [b2s_pkg::CROP_W-1:0]    ct_q, cl_q;
  logic [DMW-1:0]                iw_q, ih_q, obn_q;
  logic [b2s_pkg::OUT_W-1:0]     oh_q, ow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q  <= BW'(2);
      ct_q  <= '0;
      cl_q  <= '0;
      iw_q  <= DMW'(1);
      ih_q  <= DMW'(1);
      obn_q <= DMW'(1);
      oh_q  <= b2s_pkg::OUT_W'(1);
      ow_q  <= b2s_pkg::OUT_W'(1);
    end else if (cfg_we_i) begin
      case (b2s_pkg::reg_idx_e'(cfg_idx_i))
        b2s_pkg::REG_BLK_FACTOR:  bs_q  <= cfg_data_i[BW-1:0];
        b2s_pkg::REG_TRIM_TOP:    ct_q  <= cfg_data_i[b2s_pkg::CROP_W-1:0];
        b2s_pkg::REG_TRIM_LEFT:   cl_q  <= cfg_data_i[b2s_pkg::CROP_W-1:0];
        b2s_pkg::REG_IN_WIDTH:    iw_q  <= cfg_data_i[DMW-1:0];
        b2s_pkg::REG_IN_HEIGHT:   ih_q  <= cfg_data_i[DMW-1:0];
        b2s_pkg::REG_OUT_BATCHES: obn_q <= cfg_data_i[DMW-1:0];
        b2s_pkg::REG_OUT_HEIGHT:  oh_q  <= cfg_data_i;
        b2s_pkg::REG_OUT_WIDTH:   ow_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A zero divisor acts as one.
  logic [BW-1:0]  bs_eff;
  logic [DMW-1:0] iw_eff, ih_eff, obn_eff;
  assign bs_eff  = (bs_q  == '0) ? BW'(1)  : bs_q;
  assign iw_eff  = (iw_q  == '0) ? DMW'(1) : iw_q;
  assign ih_eff  = (ih_q  == '0) ? DMW'(1) : ih_q;
  assign obn_eff = (obn_q == '0) ? DMW'(1) : obn_q;

  b2s_pkg::cfg_t cfg;
  assign cfg = '{blk_factor: bs_eff, trim_top: ct_q, trim_left: cl_q,
                 out_height: oh_q, out_width: ow_q};

  // ---- global advance: hold everything while the output item waits ----
  logic en;
  logic out_v;
  assign en            = !out_v || m_axis_tready;
  assign s_axis_tready = en;

  // ---- divider chain ----
  logic            v1, v2, v3, v4, v5;
  logic [IW-1:0]   q1, q2, q3, q4, q5;
  logic [CHW-1:0]  ch1;
  logic [DMW-1:0]  col2, row3, ob4;
  logic [BW-1:0]   offw5;
  logic [EW-1:0]   side1;
  logic [S2W-1:0]  side2;
  logic [S3W-1:0]  side3;
  logic [S4W-1:0]  side4;
  logic [S5W-1:0]  side5;

  // split off the channel: partial products, quotient, remainder
  logic [2:0]      cd_v_q;
  logic [PLW-1:0]  cd_plo_d, cd_plo_q;
  logic [PHW-1:0]  cd_phi_d, cd_phi_q;
  logic [SMW-1:0]  cd_sum;
  logic [IW-1:0]   cd_quo_d, cd_idx0_q, cd_idx1_q, cd_quo1_q, cd_quo2_q;
  logic [CHW-1:0]  cd_ch_d, cd_ch2_q;
  logic [EW-1:0]   cd_elem0_q, cd_elem1_q, cd_elem2_q;

  always_comb begin
    cd_plo_d = PLW'(s_axis_tdata[LOW-1:0]) * PLW'(RECIP);
    cd_phi_d = PHW'(s_axis_tdata[IW-1:LOW]) * PHW'(RECIP);
    cd_sum   = {cd_phi_q, {LOW{1'b0}}} + SMW'(cd_plo_q);
    cd_quo_d = IW'(cd_sum >> SH);
    // the remainder fits in CHW bits, so the low bits suffice
    cd_ch_d  = CHW'(cd_idx1_q) - CHW'(cd_quo1_q) * CHW'(DEPTH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cd_v_q <= '0;
    end else if (en) begin
      cd_v_q <= {cd_v_q[1:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cd_plo_q   <= cd_plo_d;
      cd_phi_q   <= cd_phi_d;
      cd_idx0_q  <= s_axis_tdata[IW-1:0];
      cd_elem0_q <= s_axis_tdata[IW+EW-1:IW];
      cd_idx1_q  <= cd_idx0_q;
      cd_quo1_q  <= cd_quo_d;
      cd_elem1_q <= cd_elem0_q;
      cd_quo2_q  <= cd_quo1_q;
      cd_ch2_q   <= cd_ch_d;
      cd_elem2_q <= cd_elem1_q;
    end
  end

  assign v1    = cd_v_q[2];
  assign q1    = cd_quo2_q;
  assign ch1   = cd_ch2_q;
  assign side1 = cd_elem2_q;

  // split off the column
  b2s_div #(.DW(IW), .VW(DMW), .SW(S2W)) u_div_col (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v1), .num_i(q1), .den_i(iw_eff), .side_i({side1, ch1}),
    .valid_o(v2), .quo_o(q2), .rem_o(col2), .side_o(side2)
  );

  // split off the row; quotient is the input batch
  b2s_div #(.DW(IW), .VW(DMW), .SW(S3W)) u_div_row (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v2), .num_i(q2), .den_i(ih_eff), .side_i({side2, col2}),
    .valid_o(v3), .quo_o(q3), .rem_o(row3), .side_o(side3)
  );

  // output batch and block number
  b2s_div #(.DW(IW), .VW(DMW), .SW(S4W)) u_div_bat (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v3), .num_i(q3), .den_i(obn_eff), .side_i({side3, row3}),
    .valid_o(v4), .quo_o(q4), .rem_o(ob4), .side_o(side4)
  );

  // block offsets: row offset is the quotient, column offset the remainder
  b2s_div #(.DW(IW), .VW(BW), .SW(S5W)) u_div_blk (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v4), .num_i(q4), .den_i(bs_eff), .side_i({side4, ob4}),
    .valid_o(v5), .quo_o(q5), .rem_o(offw5), .side_o(side5)
  );

  // ---- remap stages; the last one is the output register ----
  logic [IW-1:0] dst;
  logic [EW-1:0] elem_out;
  logic          ok;

  b2s_remap #(.DEPTH(DEPTH), .CHW(CHW)) u_remap (
    .clk_i, .rst_ni, .en_i(en), .cfg_i(cfg),
    .valid_i(v5),
    .ch_i(side5[CHW+3*DMW-1:3*DMW]),
    .col_i(side5[3*DMW-1:2*DMW]),
    .row_i(side5[2*DMW-1:DMW]),
    .ob_i(side5[DMW-1:0]),
    .off_h_i(q5), .off_w_i(offw5),
    .elem_i(side5[S5W-1:CHW+3*DMW]),
    .valid_o(out_v), .dst_o(dst), .elem_o(elem_out), .ok_o(ok)
  );

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = {1'b0, elem_out, dst};
  assign m_axis_tuser  = ok;

  // ---- checks ----
  `B2S_ASSERT_NOW(a_crop_zero_idx, m_axis_tvalid && !m_axis_tuser,
                  m_axis_tdata[IW-1:0] == '0, "cropped item carries nonzero index")
  `B2S_ASSERT_NOW(a_stall_cause, !s_axis_tready,
                  m_axis_tvalid && !m_axis_tready, "input stalled without output stall")
  `B2S_ASSERT_NEXT(a_hold_out, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
                   "output item changed while stalled")

endmodule
